// ===== rtl/pmtsp_pkg.sv =====
// Package for the program map section parser.
// Holds the parse phase and result kind codes, the result record and the defaults.
// Depends on nothing.
package pmtsp_pkg;

	localparam int DESC_TAIL_BYTES_DEF = 4;
	localparam int RES_FIFO_DEPTH = 4;
	localparam logic [7:0] PMT_TABLE_ID = 8'h02;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_HEADER,
		PH_PINFO,
		PH_ENTRY_HDR,
		PH_ENTRY_DESC,
		PH_CRC
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ENTRY,
		KIND_SUMMARY,
		KIND_BAD_TABLE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] es_type;
		logic [12:0] es_pid;
		logic [11:0] es_desc_len;
		logic [31:0] descriptor_tail;
		logic [15:0] prog_number;
		logic [4:0] sect_version;
		logic current_next;
		logic [7:0] sect_index;
		logic [7:0] sect_last;
		logic [12:0] pcr_pid;
		logic [31:0] crc_value;
	} result_t;

endpackage

// ===== rtl/pmt_section_parser.sv =====
// Program map section parser: one section byte per request, results through a small queue.
// Depends on pmtsp_pkg for the phase codes, result kinds and result record.
//
// A result is written into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle; in_ready drops only when the four-entry result queue
// has fewer than two free slots, since one byte can cause two results.
// Reset: arst_n clears the parse state and empties the queue; the parser waits for a start.
module pmt_section_parser #(
	parameter int DESCRIPTOR_TAIL_BYTES = pmtsp_pkg::DESC_TAIL_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        section_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  es_type,
	output logic [12:0] es_pid,
	output logic [11:0] es_desc_len,
	output logic [31:0] descriptor_tail,
	output logic [15:0] prog_number,
	output logic [4:0]  sect_version,
	output logic        current_next,
	output logic [7:0]  sect_index,
	output logic [7:0]  sect_last,
	output logic [12:0] pcr_pid,
	output logic [31:0] crc_value
);

	localparam int TW = 8 * DESCRIPTOR_TAIL_BYTES;
	localparam int DEPTH = pmtsp_pkg::RES_FIFO_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pmtsp_pkg::phase_t phase_q, phase_d;
	logic [11:0] pos_q, pos_d;
	logic [11:0] slen_q, slen_d;
	logic [11:0] pilen_q, pilen_d;
	logic [11:0] epos_q, epos_d;
	logic [15:0] prog_q, prog_d;
	logic [4:0]  ver_q, ver_d;
	logic        cn_q, cn_d;
	logic [7:0]  secn_q, secn_d;
	logic [7:0]  lsec_q, lsec_d;
	logic [12:0] pcr_q, pcr_d;
	logic [7:0]  styp_q, styp_d;
	logic [12:0] epid_q, epid_d;
	logic [11:0] esil_q, esil_d;
	logic [TW-1:0] desc_q, desc_d;
	logic [31:0] crc_q, crc_d;

	logic [1:0] nres;
	pmtsp_pkg::result_t res0, res1;
	logic [63:0] desc_ext;
	logic [11:0] crc_start;
	logic [12:0] pos_inc;
	logic [11:0] epos_inc;

	pmtsp_pkg::result_t fifo_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic in_fire, out_fire;

	assign in_ready = (count_q <= CW'(DEPTH - 2));
	assign in_fire = in_valid && in_ready;
	assign out_valid = (count_q != '0);
	assign out_fire = out_valid && out_ready;

	function automatic pmtsp_pkg::result_t blank_res();
		pmtsp_pkg::result_t r;
		r = '0;
		return r;
	endfunction

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		slen_d = slen_q;
		pilen_d = pilen_q;
		epos_d = epos_q;
		prog_d = prog_q;
		ver_d = ver_q;
		cn_d = cn_q;
		secn_d = secn_q;
		lsec_d = lsec_q;
		pcr_d = pcr_q;
		styp_d = styp_q;
		epid_d = epid_q;
		esil_d = esil_q;
		desc_d = desc_q;
		crc_d = crc_q;
		nres = 2'd0;
		res0 = blank_res();
		res1 = blank_res();
		crc_start = (slen_q >= 12'd4) ? slen_q - 12'd4 : 12'd0;
		pos_inc = {1'b0, pos_q} + 13'd1;
		epos_inc = epos_q + 12'd1;

		if (section_start) begin
			phase_d = pmtsp_pkg::PH_LEN_HI;
			pos_d = '0;
			slen_d = '0;
			pilen_d = '0;
			epos_d = '0;
			prog_d = '0;
			ver_d = '0;
			cn_d = 1'b0;
			secn_d = '0;
			lsec_d = '0;
			pcr_d = '0;
			styp_d = '0;
			epid_d = '0;
			esil_d = '0;
			desc_d = '0;
			crc_d = '0;
			if (data_byte != pmtsp_pkg::PMT_TABLE_ID) begin
				phase_d = pmtsp_pkg::PH_IDLE;
				res0.kind = pmtsp_pkg::KIND_BAD_TABLE;
				nres = 2'd1;
			end
		end else begin
			case (phase_q)
				pmtsp_pkg::PH_IDLE: begin
				end
				pmtsp_pkg::PH_LEN_HI: begin
					slen_d = {data_byte[3:0], 8'h00};
					phase_d = pmtsp_pkg::PH_LEN_LO;
				end
				pmtsp_pkg::PH_LEN_LO: begin
					slen_d = {slen_q[11:8], data_byte};
					pos_d = '0;
					if ({slen_q[11:8], data_byte} == 12'd0) begin
						res0.kind = pmtsp_pkg::KIND_SUMMARY;
						nres = 2'd1;
						phase_d = pmtsp_pkg::PH_IDLE;
					end else begin
						phase_d = pmtsp_pkg::PH_HEADER;
					end
				end
				default: begin
					pos_d = pos_inc[11:0];
					if (pos_q >= crc_start) begin
						if ((phase_q == pmtsp_pkg::PH_ENTRY_HDR && epos_q != 12'd0) ||
							phase_q == pmtsp_pkg::PH_ENTRY_DESC) begin
							res0.kind = pmtsp_pkg::KIND_ENTRY;
							nres = 2'd1;
						end
						phase_d = pmtsp_pkg::PH_CRC;
						crc_d = {crc_q[23:0], data_byte};
						if (pos_inc >= {1'b0, slen_q}) begin
							phase_d = pmtsp_pkg::PH_IDLE;
							if (nres == 2'd1) begin
								res1.kind = pmtsp_pkg::KIND_SUMMARY;
								nres = 2'd2;
							end else begin
								res0.kind = pmtsp_pkg::KIND_SUMMARY;
								nres = 2'd1;
							end
						end
					end else begin
						case (phase_q)
							pmtsp_pkg::PH_HEADER: begin
								case (pos_q)
									12'd0: prog_d[15:8] = data_byte;
									12'd1: prog_d[7:0] = data_byte;
									12'd2: begin
										ver_d = data_byte[5:1];
										cn_d = data_byte[0];
									end
									12'd3: secn_d = data_byte;
									12'd4: lsec_d = data_byte;
									12'd5: pcr_d[12:8] = data_byte[4:0];
									12'd6: pcr_d[7:0] = data_byte;
									12'd7: pilen_d = {data_byte[3:0], 8'h00};
									default: begin
										pilen_d = {pilen_q[11:8], data_byte};
										epos_d = '0;
										phase_d = ({pilen_q[11:8], data_byte} == 12'd0) ?
											pmtsp_pkg::PH_ENTRY_HDR : pmtsp_pkg::PH_PINFO;
									end
								endcase
							end
							pmtsp_pkg::PH_PINFO: begin
								epos_d = epos_inc;
								if (epos_inc >= pilen_q) begin
									epos_d = '0;
									phase_d = pmtsp_pkg::PH_ENTRY_HDR;
								end
							end
							pmtsp_pkg::PH_ENTRY_HDR: begin
								case (epos_q)
									12'd0: begin
										styp_d = data_byte;
										epid_d = '0;
										esil_d = '0;
										desc_d = '0;
									end
									12'd1: epid_d[12:8] = data_byte[4:0];
									12'd2: epid_d[7:0] = data_byte;
									12'd3: esil_d[11:8] = data_byte[3:0];
									default: esil_d[7:0] = data_byte;
								endcase
								epos_d = epos_inc;
								if (epos_inc >= 12'd5) begin
									epos_d = '0;
									if (esil_d == 12'd0) begin
										res0.kind = pmtsp_pkg::KIND_ENTRY;
										nres = 2'd1;
									end else begin
										phase_d = pmtsp_pkg::PH_ENTRY_DESC;
									end
								end
							end
							default: begin
								desc_d = TW'({desc_q, data_byte});
								epos_d = epos_inc;
								if (epos_inc >= esil_q) begin
									res0.kind = pmtsp_pkg::KIND_ENTRY;
									nres = 2'd1;
									epos_d = '0;
									phase_d = pmtsp_pkg::PH_ENTRY_HDR;
								end
							end
						endcase
					end
				end
			endcase
		end

		desc_ext = 64'(desc_d);
		if (res0.kind == pmtsp_pkg::KIND_ENTRY) begin
			res0.es_type = styp_d;
			res0.es_pid = epid_d;
			res0.es_desc_len = esil_d;
			res0.descriptor_tail = desc_ext[31:0];
		end
		if (res0.kind != pmtsp_pkg::KIND_BAD_TABLE) begin
			res0.prog_number = prog_d;
			res0.sect_version = ver_d;
			res0.current_next = cn_d;
			res0.sect_index = secn_d;
			res0.sect_last = lsec_d;
			res0.pcr_pid = pcr_d;
		end
		if (res0.kind == pmtsp_pkg::KIND_SUMMARY) begin
			res0.crc_value = crc_d;
		end
		res1.prog_number = prog_d;
		res1.sect_version = ver_d;
		res1.current_next = cn_d;
		res1.sect_index = secn_d;
		res1.sect_last = lsec_d;
		res1.pcr_pid = pcr_d;
		res1.crc_value = crc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pmtsp_pkg::PH_IDLE;
			pos_q <= '0;
			slen_q <= '0;
			pilen_q <= '0;
			epos_q <= '0;
			prog_q <= '0;
			ver_q <= '0;
			cn_q <= 1'b0;
			secn_q <= '0;
			lsec_q <= '0;
			pcr_q <= '0;
			styp_q <= '0;
			epid_q <= '0;
			esil_q <= '0;
			desc_q <= '0;
			crc_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			slen_q <= slen_d;
			pilen_q <= pilen_d;
			epos_q <= epos_d;
			prog_q <= prog_d;
			ver_q <= ver_d;
			cn_q <= cn_d;
			secn_q <= secn_d;
			lsec_q <= lsec_d;
			pcr_q <= pcr_d;
			styp_q <= styp_d;
			epid_q <= epid_d;
			esil_q <= esil_d;
			desc_q <= desc_d;
			crc_q <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && nres != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (in_fire && nres == 2'd2) begin
			fifo_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= wr_ptr_q + PW'(nres);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (in_fire ? CW'(nres) : CW'(0)) - (out_fire ? CW'(1) : CW'(0));
		end
	end

	assign result_kind = fifo_q[rd_ptr_q].kind;
	assign es_type = fifo_q[rd_ptr_q].es_type;
	assign es_pid = fifo_q[rd_ptr_q].es_pid;
	assign es_desc_len = fifo_q[rd_ptr_q].es_desc_len;
	assign descriptor_tail = fifo_q[rd_ptr_q].descriptor_tail;
	assign prog_number = fifo_q[rd_ptr_q].prog_number;
	assign sect_version = fifo_q[rd_ptr_q].sect_version;
	assign current_next = fifo_q[rd_ptr_q].current_next;
	assign sect_index = fifo_q[rd_ptr_q].sect_index;
	assign sect_last = fifo_q[rd_ptr_q].sect_last;
	assign pcr_pid = fifo_q[rd_ptr_q].pcr_pid;
	assign crc_value = fifo_q[rd_ptr_q].crc_value;

endmodule

// ===== verif/pmt_section_parser_check.sv =====
// Checker for the program map section parser: watches the byte and result channels.
// It predicts every result from the accepted bytes and compares each field.
// Depends on pmtsp_pkg for the result kinds, parse phases and the result record.
module pmt_section_parser_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        section_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  es_type,
	input  logic [12:0] es_pid,
	input  logic [11:0] es_desc_len,
	input  logic [31:0] descriptor_tail,
	input  logic [15:0] prog_number,
	input  logic [4:0]  sect_version,
	input  logic        current_next,
	input  logic [7:0]  sect_index,
	input  logic [7:0]  sect_last,
	input  logic [12:0] pcr_pid,
	input  logic [31:0] crc_value,
	output int          fail_count,
	output int          outstanding,
	output int          entry_total,
	output int          summary_total,
	output int          reject_total
);
	timeunit 1ns;
	timeprecision 1ps;

	pmtsp_pkg::phase_t phase;
	logic [11:0] byte_pos;
	logic [11:0] sec_len;
	logic [11:0] pinfo_len;
	logic [11:0] entry_pos;
	logic [15:0] prog_num;
	logic [4:0]  version;
	logic        cur_next;
	logic [7:0]  sec_num;
	logic [7:0]  last_sec_num;
	logic [12:0] pcr;
	logic [7:0]  stype;
	logic [12:0] epid;
	logic [11:0] einfo;
	logic [31:0] desc_tail;
	logic [31:0] crc_word;

	pmtsp_pkg::result_t parsed_records[$];
	pmtsp_pkg::result_t want;

	function void clear_parse();
		phase = pmtsp_pkg::PH_IDLE;
		byte_pos = '0;
		sec_len = '0;
		pinfo_len = '0;
		entry_pos = '0;
		prog_num = '0;
		version = '0;
		cur_next = 1'b0;
		sec_num = '0;
		last_sec_num = '0;
		pcr = '0;
		stype = '0;
		epid = '0;
		einfo = '0;
		desc_tail = '0;
		crc_word = '0;
	endfunction

	function void queue_record(input pmtsp_pkg::kind_t k, input bit with_entry,
			input bit with_header, input bit with_crc);
		pmtsp_pkg::result_t r;
		r = '0;
		r.kind = k;
		if (with_entry) begin
			r.es_type = stype;
			r.es_pid = epid;
			r.es_desc_len = einfo;
			r.descriptor_tail = desc_tail;
		end
		if (with_header) begin
			r.prog_number = prog_num;
			r.sect_version = version;
			r.current_next = cur_next;
			r.sect_index = sec_num;
			r.sect_last = last_sec_num;
			r.pcr_pid = pcr;
		end
		if (with_crc)
			r.crc_value = crc_word;
		parsed_records.insert(parsed_records.size(), r);
	endfunction

	function void parse_section_byte(input logic [7:0] b, input logic start);
		logic [11:0] crc_from;
		if (start) begin
			clear_parse();
			if (b != pmtsp_pkg::PMT_TABLE_ID)
				queue_record(pmtsp_pkg::KIND_BAD_TABLE, 1'b0, 1'b0, 1'b0);
			else
				phase = pmtsp_pkg::PH_LEN_HI;
			return;
		end
		case (phase)
			pmtsp_pkg::PH_IDLE: return;
			pmtsp_pkg::PH_LEN_HI: begin
				sec_len = {b[3:0], 8'h00};
				phase = pmtsp_pkg::PH_LEN_LO;
				return;
			end
			pmtsp_pkg::PH_LEN_LO: begin
				sec_len[7:0] = b;
				byte_pos = '0;
				if (sec_len == '0) begin
					queue_record(pmtsp_pkg::KIND_SUMMARY, 1'b0, 1'b1, 1'b1);
					phase = pmtsp_pkg::PH_IDLE;
				end else begin
					phase = pmtsp_pkg::PH_HEADER;
				end
				return;
			end
			default: ;
		endcase

		crc_from = (sec_len >= 12'd4) ? sec_len - 12'd4 : 12'd0;
		if (byte_pos >= crc_from) begin
			if ((phase == pmtsp_pkg::PH_ENTRY_HDR && entry_pos != '0) ||
				phase == pmtsp_pkg::PH_ENTRY_DESC)
				queue_record(pmtsp_pkg::KIND_ENTRY, 1'b1, 1'b1, 1'b0);
			phase = pmtsp_pkg::PH_CRC;
			crc_word = {crc_word[23:0], b};
			if ({1'b0, byte_pos} + 13'd1 >= {1'b0, sec_len}) begin
				queue_record(pmtsp_pkg::KIND_SUMMARY, 1'b0, 1'b1, 1'b1);
				phase = pmtsp_pkg::PH_IDLE;
			end
			byte_pos = byte_pos + 12'd1;
			return;
		end

		case (phase)
			pmtsp_pkg::PH_HEADER: begin
				case (byte_pos)
					12'd0: prog_num[15:8] = b;
					12'd1: prog_num[7:0] = b;
					12'd2: begin
						version = b[5:1];
						cur_next = b[0];
					end
					12'd3: sec_num = b;
					12'd4: last_sec_num = b;
					12'd5: pcr[12:8] = b[4:0];
					12'd6: pcr[7:0] = b;
					12'd7: pinfo_len = {b[3:0], 8'h00};
					default: begin
						pinfo_len[7:0] = b;
						entry_pos = '0;
						phase = (pinfo_len == '0) ? pmtsp_pkg::PH_ENTRY_HDR : pmtsp_pkg::PH_PINFO;
					end
				endcase
			end
			pmtsp_pkg::PH_PINFO: begin
				entry_pos = entry_pos + 12'd1;
				if (entry_pos >= pinfo_len) begin
					entry_pos = '0;
					phase = pmtsp_pkg::PH_ENTRY_HDR;
				end
			end
			pmtsp_pkg::PH_ENTRY_HDR: begin
				case (entry_pos)
					12'd0: begin
						stype = b;
						epid = '0;
						einfo = '0;
						desc_tail = '0;
					end
					12'd1: epid[12:8] = b[4:0];
					12'd2: epid[7:0] = b;
					12'd3: einfo[11:8] = b[3:0];
					default: einfo[7:0] = b;
				endcase
				entry_pos = entry_pos + 12'd1;
				if (entry_pos >= 12'd5) begin
					entry_pos = '0;
					if (einfo == '0)
						queue_record(pmtsp_pkg::KIND_ENTRY, 1'b1, 1'b1, 1'b0);
					else
						phase = pmtsp_pkg::PH_ENTRY_DESC;
				end
			end
			default: begin
				desc_tail = {desc_tail[23:0], b};
				entry_pos = entry_pos + 12'd1;
				if (entry_pos >= einfo) begin
					queue_record(pmtsp_pkg::KIND_ENTRY, 1'b1, 1'b1, 1'b0);
					entry_pos = '0;
					phase = pmtsp_pkg::PH_ENTRY_HDR;
				end
			end
		endcase
		byte_pos = byte_pos + 12'd1;
	endfunction

	task compare_field(input string name, input logic [31:0] expected, input logic [31:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expected,
				actual);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			parsed_records.delete();
			fail_count = 0;
			entry_total = 0;
			summary_total = 0;
			reject_total = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (parsed_records.size() == 0) begin
					$display("%0t: result_kind mismatch, expected no result, actual 0x%0h",
						$time, result_kind);
					fail_count++;
				end else begin
					want = parsed_records.pop_front();
					compare_field("result_kind", 32'(want.kind), 32'(result_kind));
					compare_field("es_type", 32'(want.es_type), 32'(es_type));
					compare_field("es_pid", 32'(want.es_pid), 32'(es_pid));
					compare_field("es_desc_len", 32'(want.es_desc_len), 32'(es_desc_len));
					compare_field("descriptor_tail", want.descriptor_tail, descriptor_tail);
					compare_field("prog_number", 32'(want.prog_number), 32'(prog_number));
					compare_field("sect_version", 32'(want.sect_version), 32'(sect_version));
					compare_field("current_next", 32'(want.current_next), 32'(current_next));
					compare_field("sect_index", 32'(want.sect_index), 32'(sect_index));
					compare_field("sect_last", 32'(want.sect_last), 32'(sect_last));
					compare_field("pcr_pid", 32'(want.pcr_pid), 32'(pcr_pid));
					compare_field("crc_value", want.crc_value, crc_value);
					case (want.kind)
						pmtsp_pkg::KIND_ENTRY: entry_total++;
						pmtsp_pkg::KIND_SUMMARY: summary_total++;
						default: reject_total++;
					endcase
				end
			end
			if (in_valid && in_ready)
				parse_section_byte(data_byte, section_start);
			outstanding <= parsed_records.size();
		end
	end

endmodule

// ===== verif/pmt_section_parser_test.sv =====
// Top of the program map section parser testbench: clock, reset, bytes and result stalls.
// It drives directed and random sections into the parser and reads the verdict from the
// checker. Depends on pmtsp_pkg, pmt_section_parser and pmt_section_parser_check.
module pmt_section_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        section_start;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [7:0]  es_type;
	logic [12:0] es_pid;
	logic [11:0] es_desc_len;
	logic [31:0] descriptor_tail;
	logic [15:0] prog_number;
	logic [4:0]  sect_version;
	logic        current_next;
	logic [7:0]  sect_index;
	logic [7:0]  sect_last;
	logic [12:0] pcr_pid;
	logic [31:0] crc_value;

	int fail_count;
	int outstanding;
	int entry_total;
	int summary_total;
	int reject_total;

	int         burst_left = 0;
	int         section_byte_total = 0;
	int         sections_sent = 0;
	bit         long_hold_req = 1'b0;
	logic [7:0] section_bytes[$];

	pmt_section_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.section_start(section_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.es_type(es_type),
		.es_pid(es_pid),
		.es_desc_len(es_desc_len),
		.descriptor_tail(descriptor_tail),
		.prog_number(prog_number),
		.sect_version(sect_version),
		.current_next(current_next),
		.sect_index(sect_index),
		.sect_last(sect_last),
		.pcr_pid(pcr_pid),
		.crc_value(crc_value)
	);

	pmt_section_parser_check parse_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.section_start(section_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.es_type(es_type),
		.es_pid(es_pid),
		.es_desc_len(es_desc_len),
		.descriptor_tail(descriptor_tail),
		.prog_number(prog_number),
		.sect_version(sect_version),
		.current_next(current_next),
		.sect_index(sect_index),
		.sect_last(sect_last),
		.pcr_pid(pcr_pid),
		.crc_value(crc_value),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.entry_total(entry_total),
		.summary_total(summary_total),
		.reject_total(reject_total)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic offer_byte(input logic [7:0] value, input logic first);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 160)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		section_start <= first;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic drain_pause();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Builds one PMT section. With skewed set, the declared lengths may disagree with the
	// bytes actually present, which cuts entries short or leaves the section open.
	task automatic build_pmt(input bit skewed, input bit big);
		logic [7:0]  body[$];
		logic [7:0]  noise;
		logic [11:0] pinfo_decl;
		logic [11:0] esl_decl;
		logic [11:0] len_field;
		int          pinfo_sent;
		int          esl_sent;
		int          entries;
		int          e;
		int          i;
		repeat (7) body.insert(body.size(), pick_byte());
		pinfo_sent = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		pinfo_decl = 12'(pinfo_sent);
		if (skewed && $urandom_range(0, 1) == 1)
			pinfo_decl = 12'($urandom_range(0, 4095));
		noise = 8'($urandom_range(0, 255));
		body.insert(body.size(), {noise[7:4], pinfo_decl[11:8]});
		body.insert(body.size(), pinfo_decl[7:0]);
		for (i = 0; i < pinfo_sent; i++)
			body.insert(body.size(), pick_byte());
		entries = $urandom_range(0, 4);
		for (e = 0; e < entries; e++) begin
			if (big && e == 0)
				esl_sent = $urandom_range(256, 300);
			else
				esl_sent = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			esl_decl = 12'(esl_sent);
			if (skewed && $urandom_range(0, 2) == 0)
				esl_decl = 12'($urandom_range(0, 4095));
			body.insert(body.size(), pick_byte());
			body.insert(body.size(), pick_byte());
			body.insert(body.size(), pick_byte());
			noise = 8'($urandom_range(0, 255));
			body.insert(body.size(), {noise[7:4], esl_decl[11:8]});
			body.insert(body.size(), esl_decl[7:0]);
			for (i = 0; i < esl_sent; i++)
				body.insert(body.size(), pick_byte());
		end
		len_field = 12'(body.size() + 4);
		if (skewed) begin
			case ($urandom_range(0, 2))
				0: len_field = 12'($urandom_range(0, body.size() + 4));
				1: len_field = 12'($urandom_range(0, 4095));
				default: ;
			endcase
		end
		section_bytes.delete();
		section_bytes.insert(section_bytes.size(), pmtsp_pkg::PMT_TABLE_ID);
		noise = 8'($urandom_range(0, 255));
		section_bytes.insert(section_bytes.size(), {noise[7:4], len_field[11:8]});
		section_bytes.insert(section_bytes.size(), len_field[7:0]);
		section_bytes = {section_bytes, body};
		repeat (4) section_bytes.insert(section_bytes.size(), pick_byte());
	endtask

	task automatic send_section();
		foreach (section_bytes[i])
			offer_byte(section_bytes[i], i == 0);
		section_byte_total += section_bytes.size();
		sections_sent++;
	endtask

	initial begin
		int  pattern;
		int  pattern_left;
		int  cycle_count;
		bit  ready_now;
		pattern = 0;
		pattern_left = 0;
		cycle_count = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (pattern_left == 0) begin
				pattern = $urandom_range(0, 3);
				pattern_left = $urandom_range(30, 150);
			end
			case (pattern)
				0: ready_now = 1'b1;
				1: ready_now = 1'($urandom_range(0, 1));
				2: ready_now = ($urandom_range(0, 3) == 0);
				default: ready_now = (cycle_count % 5) != 0;
			endcase
			out_ready <= ready_now;
			pattern_left--;
			cycle_count++;
		end
	end

	initial begin
		int  flavor;
		int  keep;
		bit  big_sent;
		bit  mid_pause_done;
		logic [7:0] tid;
		big_sent = 1'b0;
		mid_pause_done = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		section_start <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		offer_byte(8'hFF, 1'b0);
		offer_byte(8'h00, 1'b0);
		offer_byte(8'hFF, 1'b1);
		offer_byte(pmtsp_pkg::PMT_TABLE_ID, 1'b0);
		offer_byte(pmtsp_pkg::PMT_TABLE_ID, 1'b1);
		offer_byte(8'hF0, 1'b0);
		offer_byte(8'h00, 1'b0);
		offer_byte(pmtsp_pkg::PMT_TABLE_ID, 1'b1);
		offer_byte(8'h00, 1'b0);
		offer_byte(8'h03, 1'b0);
		offer_byte(8'hDE, 1'b0);
		offer_byte(8'hAD, 1'b0);
		offer_byte(8'hBE, 1'b0);
		offer_byte(8'hEF, 1'b0);
		offer_byte(pmtsp_pkg::PMT_TABLE_ID, 1'b1);
		offer_byte(8'h0F, 1'b0);
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'hAB, 1'b0);
		offer_byte(8'h00, 1'b1);
		drain_pause();

		long_hold_req = 1'b1;
		while (section_byte_total < 1550) begin
			if (!mid_pause_done && section_byte_total >= 800) begin
				drain_pause();
				mid_pause_done = 1'b1;
			end
			flavor = $urandom_range(0, 19);
			if (!big_sent && section_byte_total >= 400) begin
				build_pmt(1'b0, 1'b1);
				big_sent = 1'b1;
			end else if (flavor < 12) begin
				build_pmt(1'b0, 1'b0);
			end else if (flavor < 15) begin
				build_pmt(1'b1, 1'b0);
			end else if (flavor < 17) begin
				build_pmt(flavor[0], 1'b0);
				keep = $urandom_range(1, section_bytes.size() - 1);
				while (section_bytes.size() > keep)
					void'(section_bytes.pop_back());
			end else begin
				tid = pick_byte();
				if (tid == pmtsp_pkg::PMT_TABLE_ID)
					tid = 8'h03;
				section_bytes.delete();
				section_bytes.insert(section_bytes.size(), tid);
				repeat ($urandom_range(0, 4))
					section_bytes.insert(section_bytes.size(), pick_byte());
			end
			send_section();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) offer_byte(pick_byte(), 1'b0);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d sections (%0d section bytes) with bursty input and output stalls.",
			sections_sent, section_byte_total);
		$display("Checked %0d stream entries, %0d section summaries, %0d rejected table ids.",
			entry_total, summary_total, reject_total);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
